@@ hw/rtl/kda_pkg.sv @@
// ----------------------------------------------------------------------------
// kda_pkg
// Shared types and constants of the debounced keypad with auto-repeat.
// ----------------------------------------------------------------------------
package kda_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int EVENT_W = 4;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int DIV_STEPS = 32;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_DELAY    = 3'd1;
    localparam logic [2:0] REG_SLOW     = 3'd2;
    localparam logic [2:0] REG_FAST     = 3'd3;
    localparam logic [2:0] REG_RAMP     = 3'd4;
    localparam logic [2:0] REG_MASK     = 3'd5;

    localparam logic [CFG_W-1:0]   RST_DEBOUNCE = 16'd25;
    localparam logic [CFG_W-1:0]   RST_DELAY    = 16'd350;
    localparam logic [CFG_W-1:0]   RST_SLOW     = 16'd140;
    localparam logic [CFG_W-1:0]   RST_FAST     = 16'd30;
    localparam logic [CFG_W-1:0]   RST_RAMP     = 16'd900;
    localparam logic [LEVEL_W-1:0] RST_MASK     = 8'd120;

    typedef struct packed {
        logic [CFG_W-1:0]   debounce_time;
        logic [CFG_W-1:0]   delay_time;
        logic [CFG_W-1:0]   slow_period;
        logic [CFG_W-1:0]   fast_period;
        logic [CFG_W-1:0]   ramp_time;
        logic [LEVEL_W-1:0] repeat_enable_mask;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic key_update;
        logic set_event;
        logic idx_clr;
        logic idx_inc;
        logic capture;
        logic mul;
        logic div_step;
        logic write_repeat;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic change_ok;
        logic press;
        logic idx_last;
        logic due;
        logic ramp_act;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/kda_if.sv @@
// ----------------------------------------------------------------------------
// kda_if
// Poll and report channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface kda_poll_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [7:0]  key_levels;

    modport source (output valid, output now_ms, output key_levels, input ready);
    modport sink   (input valid, input now_ms, input key_levels, output ready);
endinterface

interface kda_report_if;
    logic       valid;
    logic       ready;
    logic [3:0] key_event;

    modport source (output valid, output key_event, input ready);
    modport sink   (input valid, input key_event, output ready);
endinterface

@@ hw/rtl/kda_regs.sv @@
// ----------------------------------------------------------------------------
// kda_regs
// APB configuration registers for debounce and repeat timing.
// ----------------------------------------------------------------------------
module kda_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [kda_pkg::ADDR_W-1:0] paddr,
    input  logic [kda_pkg::DATA_W-1:0] pwdata,
    output logic [kda_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output kda_pkg::cfg_t             cfg
);
    import kda_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time      <= RST_DEBOUNCE;
            cfg_reg.delay_time         <= RST_DELAY;
            cfg_reg.slow_period        <= RST_SLOW;
            cfg_reg.fast_period        <= RST_FAST;
            cfg_reg.ramp_time          <= RST_RAMP;
            cfg_reg.repeat_enable_mask <= RST_MASK;
        end
        else if (wr_en)
        begin
            case (index)
                REG_DEBOUNCE: cfg_reg.debounce_time      <= pwdata[CFG_W-1:0];
                REG_DELAY:    cfg_reg.delay_time         <= pwdata[CFG_W-1:0];
                REG_SLOW:     cfg_reg.slow_period        <= pwdata[CFG_W-1:0];
                REG_FAST:     cfg_reg.fast_period        <= pwdata[CFG_W-1:0];
                REG_RAMP:     cfg_reg.ramp_time          <= pwdata[CFG_W-1:0];
                REG_MASK:     cfg_reg.repeat_enable_mask <= pwdata[LEVEL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_DEBOUNCE: prdata = DATA_W'(cfg_reg.debounce_time);
            REG_DELAY:    prdata = DATA_W'(cfg_reg.delay_time);
            REG_SLOW:     prdata = DATA_W'(cfg_reg.slow_period);
            REG_FAST:     prdata = DATA_W'(cfg_reg.fast_period);
            REG_RAMP:     prdata = DATA_W'(cfg_reg.ramp_time);
            REG_MASK:     prdata = DATA_W'(cfg_reg.repeat_enable_mask);
            default:      prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/kda_ctrl.sv @@
// ----------------------------------------------------------------------------
// kda_ctrl
// Sequencer: press scan, repeat scan, ramp divide, result hand-off.
// ----------------------------------------------------------------------------
module kda_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  kda_pkg::sts_t sts,
    output kda_pkg::cmd_t cmd
);
    import kda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEVEL,
        S_REPEAT,
        S_MUL,
        S_DIV,
        S_WRITE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL:
            begin
                cmd.key_update = sts.change_ok;
                if (sts.change_ok && sts.press)
                begin
                    cmd.set_event = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_REPEAT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_REPEAT:
            begin
                if (sts.due)
                begin
                    cmd.capture   = 1'b1;
                    cmd.set_event = 1'b1;
                    state_next    = S_MUL;
                end
                else if (sts.idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = sts.ramp_act ? S_DIV : S_WRITE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_repeat = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_LEVEL))
        else $error("poll transfer did not start the press scan");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending one");

    a_div_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> $past(state_reg == S_MUL || state_reg == S_DIV))
        else $error("divide entered without a product");

endmodule

@@ hw/rtl/kda_datapath.sv @@
// ----------------------------------------------------------------------------
// kda_datapath
// Per-key state, scan compare, ramp multiply and shift-subtract divider.
// ----------------------------------------------------------------------------
module kda_datapath #(
    parameter int NUM_KEYS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kda_pkg::cfg_t               cfg,
    input  logic [kda_pkg::TIME_W-1:0]  now_ms,
    input  logic [kda_pkg::LEVEL_W-1:0] key_levels,
    input  kda_pkg::cmd_t               cmd,
    output kda_pkg::sts_t               sts,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [kda_pkg::EVENT_W-1:0] key_event
);
    import kda_pkg::*;

    localparam int KW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int MAX_EVT = (NUM_KEYS < LEVEL_W) ? NUM_KEYS : LEVEL_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    logic [TIME_W-1:0]  now_reg;
    logic [LEVEL_W-1:0] levels_reg;
    logic [KW-1:0]      idx_reg;

    logic               stable_reg [NUM_KEYS];
    logic [TIME_W-1:0]  last_change_reg [NUM_KEYS];
    logic               held_reg [NUM_KEYS];
    logic [TIME_W-1:0]  press_reg [NUM_KEYS];
    logic [TIME_W-1:0]  next_rep_reg [NUM_KEYS];

    logic [EVENT_W-1:0] event_reg;
    logic               out_valid_reg;
    logic [EVENT_W-1:0] key_event_reg;

    logic [CFG_W-1:0]   held_lo_reg;
    logic               ramp_act_reg;
    logic [TIME_W-1:0]  quo_reg;
    logic [CFG_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [NUM_KEYS-1:0] raw_ext;
    logic [NUM_KEYS-1:0] rep_en_ext;

    // keys past the eight inputs read released and never repeat
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_ext
        if (k < LEVEL_W)
        begin : g_in
            assign raw_ext[k]    = levels_reg[k];
            assign rep_en_ext[k] = cfg.repeat_enable_mask[k];
        end
        else
        begin : g_pad
            assign raw_ext[k]    = 1'b1;
            assign rep_en_ext[k] = 1'b0;
        end
    end

    logic               lv;
    logic [TIME_W-1:0]  since_change;
    logic [TIME_W-1:0]  to_repeat;
    logic [TIME_W-1:0]  held_for;
    logic [CFG_W-1:0]   fast_c;
    logic [CFG_W-1:0]   span;
    logic [CFG_W-1:0]   period;
    logic [EVENT_W-1:0] key_code;
    logic [CFG_W:0]     rem_sh;
    logic               sub_ok;

    assign lv           = raw_ext[idx_reg];
    assign since_change = now_reg - last_change_reg[idx_reg];
    assign to_repeat    = now_reg - next_rep_reg[idx_reg];
    assign held_for     = now_reg - press_reg[idx_reg];
    assign fast_c       = (cfg.fast_period > cfg.slow_period) ?
                          cfg.slow_period : cfg.fast_period;
    assign span         = cfg.slow_period - fast_c;
    assign period       = ramp_act_reg ? (cfg.slow_period - quo_reg[CFG_W-1:0])
                                       : fast_c;
    assign key_code     = EVENT_W'(32'(idx_reg) + 32'd1);
    assign rem_sh       = {rem_reg, quo_reg[TIME_W-1]};
    assign sub_ok       = (rem_sh >= {1'b0, cfg.ramp_time});

    assign sts.change_ok = (lv != stable_reg[idx_reg]) &&
                           (since_change >= TIME_W'(cfg.debounce_time));
    assign sts.press     = !lv;
    assign sts.idx_last  = (idx_reg == KW'(NUM_KEYS - 1));
    assign sts.due       = held_reg[idx_reg] && rep_en_ext[idx_reg] && !to_repeat[TIME_W-1];
    assign sts.ramp_act  = ramp_act_reg;
    assign sts.div_last  = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign key_event = key_event_reg;

    // control and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                stable_reg[k]      <= 1'b1;
                last_change_reg[k] <= '0;
                held_reg[k]        <= 1'b0;
                press_reg[k]       <= '0;
                next_rep_reg[k]    <= '0;
            end
        end
        else
        begin
            if (cmd.load || cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + KW'(1);
            end

            if (cmd.key_update)
            begin
                last_change_reg[idx_reg] <= now_reg;
                stable_reg[idx_reg]      <= lv;
                held_reg[idx_reg]        <= !lv;
                if (!lv)
                begin
                    press_reg[idx_reg]    <= now_reg;
                    next_rep_reg[idx_reg] <= now_reg + TIME_W'(cfg.delay_time);
                end
            end

            if (cmd.write_repeat)
            begin
                next_rep_reg[idx_reg] <= now_reg + TIME_W'(period);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: poll, event code, ramp arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg    <= now_ms;
            levels_reg <= key_levels;
            event_reg  <= '0;
        end
        else if (cmd.set_event)
        begin
            event_reg <= key_code;
        end

        if (cmd.capture)
        begin
            held_lo_reg  <= held_for[CFG_W-1:0];
            ramp_act_reg <= (cfg.ramp_time != '0) &&
                            (held_for < TIME_W'(cfg.ramp_time));
        end

        // product seeds the dividend; quotient shifts in behind it
        if (cmd.mul)
        begin
            quo_reg <= TIME_W'(span) * TIME_W'(held_lo_reg);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= sub_ok ? CFG_W'(rem_sh - {1'b0, cfg.ramp_time})
                              : rem_sh[CFG_W-1:0];
            quo_reg <= {quo_reg[TIME_W-2:0], sub_ok};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end

        if (cmd.out_load)
        begin
            key_event_reg <= event_reg;
        end
    end

    a_evt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(key_event_reg) <= MAX_EVT))
        else $error("key event outside the key range");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (cfg.ramp_time != '0))
        else $error("ramp divide with a zero divisor");

    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_repeat && ramp_act_reg) |-> (quo_reg[TIME_W-1:CFG_W] == '0))
        else $error("ramp drop exceeds the slow period");

    a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.key_update && !lv && idx_reg == '0) |=> held_reg[0])
        else $error("accepted press did not mark the key held");

endmodule

@@ hw/rtl/key_debounce_autorepeat.sv @@
// ----------------------------------------------------------------------------
// key_debounce_autorepeat
// Debounced keypad scanner with ramped typematic auto-repeat.
// ----------------------------------------------------------------------------
// One poll (timestamp plus raw active-low key levels) is processed at a time
// and yields exactly one report: a key code 1..8 for a press or a repeat, or
// 0 for none. The sequencer visits one key per cycle in a press pass, which
// ends at the first accepted press, and then, if none was found, in a repeat
// pass, which ends at the first due repeat; a due repeat with an active ramp
// runs a 32-step shift-subtract divider for its next period. The next poll
// can be taken in the cycle after the report is loaded into the output
// register, which holds it until the sink takes it.
module key_debounce_autorepeat #(
    parameter int NUM_KEYS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    kda_poll_if.sink           poll,
    kda_report_if.source       report,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import kda_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic in_ready;
    logic out_valid;
    logic [EVENT_W-1:0] key_event;

    assign poll.ready       = in_ready;
    assign report.valid     = out_valid;
    assign report.key_event = key_event;

    kda_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (poll.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kda_datapath #(
        .NUM_KEYS (NUM_KEYS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .now_ms     (poll.now_ms),
        .key_levels (poll.key_levels),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (report.ready),
        .key_event  (key_event)
    );

endmodule
